// ===== hdl/rpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants of the RTP packet parser: word formats, parser
// phases, result kinds and end status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rpp_pkg;

  localparam int LENGTH_BITS_DEF = 18;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  version;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] sync_source;
    logic [31:0] data_word;
    logic [7:0]  ext_id;
    logic        element_end;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_CSRC    = 4'd1,
    PH_EXTHDR  = 4'd2,
    PH_ONE_HDR = 4'd3,
    PH_TWO_ID  = 4'd4,
    PH_TWO_LEN = 4'd5,
    PH_ELEM    = 4'd6,
    PH_RAW     = 4'd7,
    PH_SKIP    = 4'd8,
    PH_PAYLOAD = 4'd9
  } phase_t;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_CSRC    = 3'd1;
  localparam logic [2:0] KIND_PROFILE = 3'd2;
  localparam logic [2:0] KIND_ELEMENT = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_STATUS  = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT   = 3'd1;
  localparam logic [2:0] ST_EXTHDR_SHORT = 3'd2;
  localparam logic [2:0] ST_EXT_SHORT   = 3'd3;
  localparam logic [2:0] ST_PAD_LARGE   = 3'd4;

  localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
  localparam logic [11:0] PROFILE_TWO_BYTE = 12'h100;
  localparam logic [3:0]  ID_RESERVED      = 4'hF;

endpackage

`default_nettype wire

// ===== hdl/rpp_front.sv =====
// ----------------------------------------------------------------------------
// rpp_front
// Byte classifier: tracks the packet phase and turns each byte into zero,
// one or two result words for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_front import rpp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire in_word_t  in_item,
  output out_word_t      res0,
  output out_word_t      res1,
  output logic [1:0]     res_cnt
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] byte_count_r, byte_count_nxt;
  logic [31:0]            shift_r, shift_nxt;
  logic [63:0]            hdr0_r, hdr0_nxt;
  logic [31:0]            hdr1_r, hdr1_nxt;
  logic [3:0]             csrc_left_r, csrc_left_nxt;
  logic [15:0]            profile_r, profile_nxt;
  logic [17:0]            ext_left_r, ext_left_nxt;
  logic [8:0]             elem_left_r, elem_left_nxt;
  logic [LENGTH_BITS-1:0] pstart_r, pstart_nxt;
  logic [1:0]             flags_r, flags_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR;
      byte_count_r <= '0;
      shift_r      <= '0;
      hdr0_r       <= '0;
      hdr1_r       <= '0;
      csrc_left_r  <= '0;
      profile_r    <= '0;
      ext_left_r   <= '0;
      elem_left_r  <= '0;
      pstart_r     <= '0;
      flags_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      shift_r      <= shift_nxt;
      hdr0_r       <= hdr0_nxt;
      hdr1_r       <= hdr1_nxt;
      csrc_left_r  <= csrc_left_nxt;
      profile_r    <= profile_nxt;
      ext_left_r   <= ext_left_nxt;
      elem_left_r  <= elem_left_nxt;
      pstart_r     <= pstart_nxt;
      flags_r      <= flags_nxt;
    end
  end

  logic [7:0]             b;
  logic [7:0]             b0;
  logic [7:0]             b1;
  phase_t                 hdr_phase;
  logic                   main_v;
  out_word_t              main_w;
  out_word_t              stat_w;
  logic [LENGTH_BITS-1:0] avail;
  logic [LENGTH_BITS-1:0] pad;

  always_comb begin
    if (profile_r == PROFILE_ONE_BYTE) begin
      hdr_phase = PH_ONE_HDR;
    end else if (profile_r[15:4] == PROFILE_TWO_BYTE) begin
      hdr_phase = PH_TWO_ID;
    end else begin
      hdr_phase = PH_RAW;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    shift_nxt      = shift_r;
    hdr0_nxt       = hdr0_r;
    hdr1_nxt       = hdr1_r;
    csrc_left_nxt  = csrc_left_r;
    profile_nxt    = profile_r;
    ext_left_nxt   = ext_left_r;
    elem_left_nxt  = elem_left_r;
    pstart_nxt     = pstart_r;
    flags_nxt      = flags_r;
    b              = in_item.data_byte;
    b0             = '0;
    b1             = '0;
    main_v         = 1'b0;
    main_w         = '0;
    stat_w         = '0;
    avail          = '0;
    pad            = '0;
    res0           = '0;
    res1           = '0;
    res_cnt        = 2'd0;

    if (accept) begin
      byte_count_nxt = (byte_count_r == LEN_MAX) ? byte_count_r : byte_count_r + 1'b1;
      if (phase_r inside {[PH_ONE_HDR:PH_SKIP]} && ext_left_r != '0) begin
        ext_left_nxt = ext_left_r - 1'b1;
      end

      case (phase_r)
        PH_HDR: begin
          if (byte_count_r < LENGTH_BITS'(8)) begin
            hdr0_nxt = {hdr0_r[55:0], b};
          end else begin
            hdr1_nxt = {hdr1_r[23:0], b};
          end
          if (byte_count_r >= LENGTH_BITS'(11)) begin
            b0                  = hdr0_nxt[63:56];
            b1                  = hdr0_nxt[55:48];
            main_v              = 1'b1;
            main_w.kind         = KIND_HEADER;
            main_w.data_word    = {26'd0, b0[5:0]};
            main_w.version      = b0[7:6];
            main_w.marker       = b1[7];
            main_w.payload_type = b1[6:0];
            main_w.sequence_res = hdr0_nxt[47:32];
            main_w.timestamp    = hdr0_nxt[31:0];
            main_w.sync_source  = hdr1_nxt;
            flags_nxt           = {b0[4], b0[5]};
            csrc_left_nxt       = b0[3:0];
            if (b0[3:0] != 4'd0) begin
              phase_nxt = PH_CSRC;
            end else if (b0[4]) begin
              phase_nxt = PH_EXTHDR;
            end else begin
              phase_nxt  = PH_PAYLOAD;
              pstart_nxt = byte_count_nxt;
            end
          end
        end
        PH_CSRC: begin
          shift_nxt = {shift_r[23:0], b};
          if (byte_count_r[1:0] == 2'd3) begin
            main_v           = 1'b1;
            main_w.kind      = KIND_CSRC;
            main_w.data_word = shift_nxt;
            csrc_left_nxt    = csrc_left_r - 1'b1;
            if (csrc_left_nxt == 4'd0) begin
              if (flags_r[1]) begin
                phase_nxt = PH_EXTHDR;
              end else begin
                phase_nxt  = PH_PAYLOAD;
                pstart_nxt = byte_count_nxt;
              end
            end
          end
        end
        PH_EXTHDR: begin
          shift_nxt = {shift_r[23:0], b};
          if (byte_count_r[1:0] == 2'd1) begin
            profile_nxt = shift_nxt[15:0];
          end
          if (byte_count_r[1:0] == 2'd3) begin
            ext_left_nxt     = {shift_nxt[15:0], 2'b00};
            main_v           = 1'b1;
            main_w.kind      = KIND_PROFILE;
            main_w.data_word = {16'd0, profile_r};
            if (shift_nxt[15:0] == 16'd0) begin
              phase_nxt  = PH_PAYLOAD;
              pstart_nxt = byte_count_nxt;
            end else begin
              phase_nxt = hdr_phase;
            end
            shift_nxt = '0;
          end
        end
        PH_ONE_HDR: begin
          if (b != 8'h00) begin
            if (b[7:4] == ID_RESERVED) begin
              phase_nxt = PH_SKIP;
            end else begin
              shift_nxt     = {28'd0, b[7:4]};
              elem_left_nxt = {5'd0, b[3:0]} + 9'd1;
              phase_nxt     = PH_ELEM;
            end
          end
        end
        PH_TWO_ID: begin
          if (b != 8'h00) begin
            shift_nxt = {24'd0, b};
            phase_nxt = PH_TWO_LEN;
          end
        end
        PH_TWO_LEN: begin
          elem_left_nxt = {1'b0, b};
          phase_nxt     = (b == 8'h00) ? PH_TWO_ID : PH_ELEM;
        end
        PH_ELEM: begin
          if (elem_left_r != '0) begin
            elem_left_nxt = elem_left_r - 1'b1;
          end
          main_v             = 1'b1;
          main_w.kind        = KIND_ELEMENT;
          main_w.data_word   = {24'd0, b};
          main_w.ext_id      = shift_r[7:0];
          main_w.element_end = (elem_left_nxt == '0) || (ext_left_nxt == '0);
          if (elem_left_nxt == '0) begin
            phase_nxt = hdr_phase;
          end
        end
        PH_RAW: begin
          main_v             = 1'b1;
          main_w.kind        = KIND_ELEMENT;
          main_w.data_word   = {24'd0, b};
          main_w.element_end = (ext_left_nxt == '0);
        end
        PH_SKIP: begin
          main_v = 1'b0;
        end
        default: begin
          main_v           = 1'b1;
          main_w.kind      = KIND_PAYLOAD;
          main_w.data_word = {24'd0, b};
        end
      endcase

      // The end of the extension region ends the walk wherever it stands.
      if (phase_nxt inside {[PH_ONE_HDR:PH_SKIP]} && ext_left_nxt == '0) begin
        phase_nxt  = PH_PAYLOAD;
        pstart_nxt = byte_count_nxt;
      end

      if (in_item.end_of_packet) begin
        stat_w.kind = KIND_STATUS;
        if (phase_nxt == PH_HDR || phase_nxt == PH_CSRC) begin
          stat_w.status = ST_HDR_SHORT;
        end else if (phase_nxt == PH_EXTHDR) begin
          stat_w.status = ST_EXTHDR_SHORT;
        end else if (phase_nxt != PH_PAYLOAD) begin
          stat_w.status = ST_EXT_SHORT;
        end else begin
          avail = (byte_count_nxt >= pstart_nxt) ? byte_count_nxt - pstart_nxt : '0;
          pad   = flags_nxt[0] ? LENGTH_BITS'(b) : '0;
          if (pad > avail) begin
            stat_w.status = ST_PAD_LARGE;
          end else begin
            stat_w.status    = ST_OK;
            stat_w.data_word = 32'(avail - pad);
          end
        end
        phase_nxt      = PH_HDR;
        byte_count_nxt = '0;
        shift_nxt      = '0;
        hdr0_nxt       = '0;
        hdr1_nxt       = '0;
        csrc_left_nxt  = '0;
        profile_nxt    = '0;
        ext_left_nxt   = '0;
        elem_left_nxt  = '0;
        pstart_nxt     = '0;
        flags_nxt      = '0;
      end

      stat_w.last = 1'b1;
      if (main_v) begin
        res0      = main_w;
        res0.last = !in_item.end_of_packet;
        res1      = stat_w;
        res_cnt   = in_item.end_of_packet ? 2'd2 : 2'd1;
      end else if (in_item.end_of_packet) begin
        res0    = stat_w;
        res_cnt = 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpp_queue.sv =====
// ----------------------------------------------------------------------------
// rpp_queue
// Result queue: takes up to two words a cycle from the classifier and
// hands out one word a cycle, on each pop, to the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_queue import rpp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire out_word_t wr0,
  input  wire out_word_t wr1,
  input  wire logic [1:0] wr_cnt,
  input  wire logic      pop,
  output out_word_t      rd,
  output logic           empty,
  output logic           full
);

  out_word_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wp_r, wp_nxt;
  logic [QUEUE_AW-1:0]   rp_r, rp_nxt;
  logic [QUEUE_AW:0]     cnt_r, cnt_nxt;
  logic                  do_pop;

  assign empty  = (cnt_r == '0);
  // Two free slots are kept so that any byte can be taken.
  assign full   = (cnt_r > (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign do_pop = pop && !empty;
  assign rd     = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + QUEUE_AW'(wr_cnt);
    rp_nxt  = rp_r + QUEUE_AW'(do_pop);
    cnt_nxt = cnt_r + (QUEUE_AW + 1)'(wr_cnt) - (QUEUE_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wp_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wp_r + 1'b1] <= wr1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtp_packet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// rtp_packet_parser_unit
// RTP packet parser: fixed header, CSRC list, header extension elements in
// one-byte, two-byte or plain form, payload bytes and an end status word.
// ----------------------------------------------------------------------------
//
//   channel   handshake        word          direction
//   input     push / full      in_item       one packet byte per word
//   result    empty / pop      out_item      parsed header, element, payload
//                                            or status word
//
// One byte is accepted per cycle while full is low; each byte is classified in
// the cycle it is accepted and its zero, one or two result words are written to
// a four-entry queue, so a result is in the queue from the cycle after its byte.
// The rate is set by the queue: full rises while fewer than two slots are
// free, so with pop held high the block sustains one byte per cycle.
// Reset is synchronous and active low; it returns the parser to the start of
// a packet and empties the queue.
// A stalled consumer only fills the queue; the classifier keeps no other
// backlog.
`default_nettype none

module rtp_packet_parser_unit import rpp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire in_word_t  in_item,
  output logic           empty,
  input  wire logic      pop,
  output out_word_t      out_item
);

  out_word_t  res0;
  out_word_t  res1;
  logic [1:0] res_cnt;
  logic       accept;

  // A byte is taken whenever the queue can absorb its worst case of two words.
  assign accept = push && !full;

  rpp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  rpp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr0    (res0),
    .wr1    (res1),
    .wr_cnt (res_cnt),
    .pop    (pop),
    .rd     (out_item),
    .empty  (empty),
    .full   (full)
  );

endmodule

`default_nettype wire

// ===== hdl/rpp_checker.sv =====
// ----------------------------------------------------------------------------
// rpp_checker
// Port-level checks of the RTP packet parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_checker import rpp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      push,
  input wire logic      full,
  input wire in_word_t  in_item,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_word_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("queue not empty after reset");

  a_waiting_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("waiting word changed or vanished");

  a_eop_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_item.end_of_packet |=> !empty)
    else $error("end of packet produced no status word");

  a_idle_stays_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !(push && !full) |=> empty)
    else $error("word appeared without an input byte");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.kind == KIND_STATUS |-> out_item.last)
    else $error("status word not marked last");

endmodule

bind rtp_packet_parser_unit rpp_checker u_rpp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .in_item  (in_item),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

`default_nettype wire
